// ----- rtl/cmos_6502_alu_and_flags_unit_macros.svh -----
// Assertion macros shared by the 65C02 ALU and flags unit.
// Expects signals named clk and rst in the module that uses them.
`ifndef CMOS_6502_ALU_AND_FLAGS_UNIT_MACROS_SVH
`define CMOS_6502_ALU_AND_FLAGS_UNIT_MACROS_SVH

// Checked at every edge, reset included.
`define C6502ALU_CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is low.
`define C6502ALU_CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- rtl/c6502alu_pkg.sv -----
// Types and constants of the 65C02 ALU and flags unit.
// No dependencies; used by the execute logic and the top level.
`default_nettype none

package c6502alu_pkg;

  typedef enum logic [5:0] {
    K_LDA    = 6'd0,
    K_LDX    = 6'd1,
    K_LDY    = 6'd2,
    K_ORA    = 6'd3,
    K_AND    = 6'd4,
    K_EOR    = 6'd5,
    K_ADC    = 6'd6,
    K_SBC    = 6'd7,
    K_CMP    = 6'd8,
    K_CPX    = 6'd9,
    K_CPY    = 6'd10,
    K_BIT    = 6'd11,
    K_BITIMM = 6'd12,
    K_ASL    = 6'd13,
    K_LSR    = 6'd14,
    K_ROL    = 6'd15,
    K_ROR    = 6'd16,
    K_INC    = 6'd17,
    K_DEC    = 6'd18,
    K_TSB    = 6'd19,
    K_TRB    = 6'd20,
    K_INX    = 6'd21,
    K_INY    = 6'd22,
    K_DEX    = 6'd23,
    K_DEY    = 6'd24,
    K_TAX    = 6'd25,
    K_TAY    = 6'd26,
    K_TXA    = 6'd27,
    K_TYA    = 6'd28,
    K_CLC    = 6'd29,
    K_SEC    = 6'd30,
    K_CLI    = 6'd31,
    K_SEI    = 6'd32,
    K_CLD    = 6'd33,
    K_SED    = 6'd34,
    K_CLV    = 6'd35,
    K_PLP    = 6'd36,
    K_BRANCH = 6'd37,
    K_RMB    = 6'd38,
    K_SMB    = 6'd39,
    K_BBR    = 6'd40,
    K_BBS    = 6'd41
  } kind_t;

  // Branch condition groups, selector[2:1]; selector[0] picks flag set.
  localparam logic [1:0] COND_N = 2'd0;
  localparam logic [1:0] COND_V = 2'd1;
  localparam logic [1:0] COND_C = 2'd2;
  localparam logic [1:0] COND_Z = 2'd3;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  localparam flags_t FLAGS_RESET = flags_t'(6'b000100);

  typedef struct packed {
    logic [7:0] wb;
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    flags_t     flags;
    logic       taken;
  } exec_result_t;

endpackage

`default_nettype wire

// ----- rtl/c6502alu_if.sv -----
// Valid/ready channel interfaces of the 65C02 ALU and flags unit.
// No package dependencies; one interface per channel.
`default_nettype none

interface c6502alu_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] kind;
  logic [7:0] operand;
  logic       on_accumulator;
  logic [2:0] selector;

  modport source (output valid, kind, operand, on_accumulator, selector, input ready);
  modport sink   (input valid, kind, operand, on_accumulator, selector, output ready);
endinterface

interface c6502alu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] write_back;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] status_out;
  logic       taken;

  modport source (output valid, write_back, acc_out, x_out, y_out, status_out, taken,
                  input ready);
  modport sink   (input valid, write_back, acc_out, x_out, y_out, status_out, taken,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/c6502alu_exec.sv -----
// Combinational execute logic: one decoded operation against A, X, Y and flags.
// Depends on c6502alu_pkg (kind_t, flags_t, exec_result_t).
`default_nettype none

module c6502alu_exec (
  input  var c6502alu_pkg::kind_t        kind,
  input  var logic [7:0]                 operand,
  input  var logic                       on_acc,
  input  var logic [2:0]                 selector,
  input  var logic [7:0]                 acc,
  input  var logic [7:0]                 x,
  input  var logic [7:0]                 y,
  input  var c6502alu_pkg::flags_t       flags,
  output c6502alu_pkg::exec_result_t     res
);

  function automatic c6502alu_pkg::flags_t set_nz(c6502alu_pkg::flags_t f,
                                                  logic [7:0] r);
    c6502alu_pkg::flags_t t;
    t   = f;
    t.z = (r == 8'h00);
    t.n = r[7];
    return t;
  endfunction

  logic [7:0] bitmask;
  logic [7:0] src;
  logic [8:0] bin_add;
  logic [8:0] bin_sub;
  logic [4:0] lo_a;
  logic [4:0] lo_ad;
  logic [5:0] hi_a;
  logic [5:0] hi_ad;
  logic [5:0] lo_s;
  logic [5:0] lo_sd;
  logic [5:0] hi_s;
  logic [5:0] hi_sd;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_r;
  logic       sh_c;
  logic [7:0] incdec;
  logic       cond_f;

  always_comb begin
    bitmask = 8'h01 << selector;
    src     = on_acc ? acc : operand;

    bin_add = {1'b0, acc} + {1'b0, operand} + {8'h00, flags.c};
    bin_sub = {1'b0, acc} + {1'b0, ~operand} + {8'h00, flags.c};

    // Decimal add, nibble at a time; invalid digits go through unchecked
    lo_a  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'h0, flags.c};
    lo_ad = (lo_a > 5'd9) ? lo_a + 5'd6 : lo_a;
    hi_a  = {2'b00, acc[7:4]} + {2'b00, operand[7:4]} + {5'd0, (lo_a > 5'd9)};
    hi_ad = (hi_a > 6'd9) ? hi_a + 6'd6 : hi_a;

    // Decimal subtract, sign bit [5] marks a borrow from the nibble
    lo_s  = {2'b00, acc[3:0]} - {2'b00, operand[3:0]} - {5'd0, ~flags.c};
    lo_sd = lo_s[5] ? lo_s - 6'd6 : lo_s;
    hi_s  = {2'b00, acc[7:4]} - {2'b00, operand[7:4]} - {5'd0, lo_s[5]};
    hi_sd = hi_s[5] ? hi_s - 6'd6 : hi_s;

    case (kind)
      c6502alu_pkg::K_CPX: cmp_reg = x;
      c6502alu_pkg::K_CPY: cmp_reg = y;
      default:             cmp_reg = acc;
    endcase
    cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    case (kind)
      c6502alu_pkg::K_ASL: begin
        sh_r = {src[6:0], 1'b0};
        sh_c = src[7];
      end
      c6502alu_pkg::K_LSR: begin
        sh_r = {1'b0, src[7:1]};
        sh_c = src[0];
      end
      c6502alu_pkg::K_ROL: begin
        sh_r = {src[6:0], flags.c};
        sh_c = src[7];
      end
      default: begin
        sh_r = {flags.c, src[7:1]};
        sh_c = src[0];
      end
    endcase

    incdec = (kind == c6502alu_pkg::K_INC) ? src + 8'h01 : src - 8'h01;

    case (selector[2:1])
      c6502alu_pkg::COND_N: cond_f = flags.n;
      c6502alu_pkg::COND_V: cond_f = flags.v;
      c6502alu_pkg::COND_C: cond_f = flags.c;
      default:              cond_f = flags.z;
    endcase

    res.wb    = operand;
    res.acc   = acc;
    res.x     = x;
    res.y     = y;
    res.flags = flags;
    res.taken = 1'b0;

    case (kind)
      c6502alu_pkg::K_LDA: begin
        res.acc   = operand;
        res.flags = set_nz(flags, operand);
      end
      c6502alu_pkg::K_LDX: begin
        res.x     = operand;
        res.flags = set_nz(flags, operand);
      end
      c6502alu_pkg::K_LDY: begin
        res.y     = operand;
        res.flags = set_nz(flags, operand);
      end
      c6502alu_pkg::K_ORA: begin
        res.acc   = acc | operand;
        res.flags = set_nz(flags, acc | operand);
      end
      c6502alu_pkg::K_AND: begin
        res.acc   = acc & operand;
        res.flags = set_nz(flags, acc & operand);
      end
      c6502alu_pkg::K_EOR: begin
        res.acc   = acc ^ operand;
        res.flags = set_nz(flags, acc ^ operand);
      end
      c6502alu_pkg::K_ADC: begin
        if (flags.d) begin
          res.acc = {hi_ad[3:0], lo_ad[3:0]};
        end else begin
          res.acc = bin_add[7:0];
        end
        res.flags   = set_nz(flags, res.acc);
        res.flags.v = ~(acc[7] ^ operand[7]) & (acc[7] ^ bin_add[7]);
        res.flags.c = flags.d ? (hi_ad > 6'd15) : bin_add[8];
      end
      c6502alu_pkg::K_SBC: begin
        if (flags.d) begin
          res.acc = {hi_sd[3:0], lo_sd[3:0]};
        end else begin
          res.acc = bin_sub[7:0];
        end
        res.flags   = set_nz(flags, res.acc);
        res.flags.v = (acc[7] ^ operand[7]) & (acc[7] ^ bin_sub[7]);
        res.flags.c = bin_sub[8];
      end
      c6502alu_pkg::K_CMP, c6502alu_pkg::K_CPX, c6502alu_pkg::K_CPY: begin
        res.flags   = set_nz(flags, cmp_diff[7:0]);
        res.flags.c = ~cmp_diff[8];
      end
      c6502alu_pkg::K_BIT: begin
        res.flags.z = ((acc & operand) == 8'h00);
        res.flags.n = operand[7];
        res.flags.v = operand[6];
      end
      c6502alu_pkg::K_BITIMM: begin
        res.flags.z = ((acc & operand) == 8'h00);
      end
      c6502alu_pkg::K_ASL, c6502alu_pkg::K_LSR, c6502alu_pkg::K_ROL,
      c6502alu_pkg::K_ROR: begin
        if (on_acc) begin
          res.acc = sh_r;
        end else begin
          res.wb = sh_r;
        end
        res.flags   = set_nz(flags, sh_r);
        res.flags.c = sh_c;
      end
      c6502alu_pkg::K_INC, c6502alu_pkg::K_DEC: begin
        if (on_acc) begin
          res.acc = incdec;
        end else begin
          res.wb = incdec;
        end
        res.flags = set_nz(flags, incdec);
      end
      c6502alu_pkg::K_TSB: begin
        res.flags.z = ((acc & operand) == 8'h00);
        res.wb      = operand | acc;
      end
      c6502alu_pkg::K_TRB: begin
        res.flags.z = ((acc & operand) == 8'h00);
        res.wb      = operand & ~acc;
      end
      c6502alu_pkg::K_INX: begin
        res.x     = x + 8'h01;
        res.flags = set_nz(flags, x + 8'h01);
      end
      c6502alu_pkg::K_INY: begin
        res.y     = y + 8'h01;
        res.flags = set_nz(flags, y + 8'h01);
      end
      c6502alu_pkg::K_DEX: begin
        res.x     = x - 8'h01;
        res.flags = set_nz(flags, x - 8'h01);
      end
      c6502alu_pkg::K_DEY: begin
        res.y     = y - 8'h01;
        res.flags = set_nz(flags, y - 8'h01);
      end
      c6502alu_pkg::K_TAX: begin
        res.x     = acc;
        res.flags = set_nz(flags, acc);
      end
      c6502alu_pkg::K_TAY: begin
        res.y     = acc;
        res.flags = set_nz(flags, acc);
      end
      c6502alu_pkg::K_TXA: begin
        res.acc   = x;
        res.flags = set_nz(flags, x);
      end
      c6502alu_pkg::K_TYA: begin
        res.acc   = y;
        res.flags = set_nz(flags, y);
      end
      c6502alu_pkg::K_CLC: res.flags.c = 1'b0;
      c6502alu_pkg::K_SEC: res.flags.c = 1'b1;
      c6502alu_pkg::K_CLI: res.flags.i = 1'b0;
      c6502alu_pkg::K_SEI: res.flags.i = 1'b1;
      c6502alu_pkg::K_CLD: res.flags.d = 1'b0;
      c6502alu_pkg::K_SED: res.flags.d = 1'b1;
      c6502alu_pkg::K_CLV: res.flags.v = 1'b0;
      c6502alu_pkg::K_PLP: begin
        // status bits 5 and 4 have no storage
        res.flags = {operand[7:6], operand[3:0]};
      end
      c6502alu_pkg::K_BRANCH: res.taken = selector[0] ? cond_f : ~cond_f;
      c6502alu_pkg::K_RMB:    res.wb    = operand & ~bitmask;
      c6502alu_pkg::K_SMB:    res.wb    = operand | bitmask;
      c6502alu_pkg::K_BBR:    res.taken = ((operand & bitmask) == 8'h00);
      c6502alu_pkg::K_BBS:    res.taken = ((operand & bitmask) != 8'h00);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cmos_6502_alu_and_flags_unit.sv -----
// 65C02 ALU and flags unit: A, X, Y and the N V D I Z C flags.
// Depends on c6502alu_pkg, c6502alu_if.sv, c6502alu_exec and the macros header.
//
// Usage:
//   in  : one decoded operation per transfer (kind, operand, on_accumulator,
//         selector). out : one result per operation, in order (write_back,
//         acc_out, x_out, y_out, status_out as NV11DIZC, taken).
//   An operation is captured in an input register, executes in combinational
//   logic against the architectural registers, and lands in the result
//   register; A, X, Y and flags update at that same edge.
//   out.valid is driven by the result register, which is loaded from the
//   input register when the operation executes.
//   Throughput: one operation per cycle while out.ready stays high; the flag
//   feedback loop runs from the flags register through the execute logic.
//   Stall: while a result waits in the output register, one more operation
//   can sit in the input register; in.ready drops only when both are full.
//   Reset (rst, synchronous): both registers empty, A = X = Y = 0, only I set.
`default_nettype none
`include "cmos_6502_alu_and_flags_unit_macros.svh"

module cmos_6502_alu_and_flags_unit (
  input  var logic        clk,
  input  var logic        rst,
  c6502alu_in_if.sink     in,
  c6502alu_out_if.source  out
);

  logic                        s1_valid;
  c6502alu_pkg::kind_t         s1_kind;
  logic [7:0]                  s1_operand;
  logic                        s1_on_acc;
  logic [2:0]                  s1_sel;

  logic [7:0]                  acc;
  logic [7:0]                  index_x;
  logic [7:0]                  index_y;
  c6502alu_pkg::flags_t        flags;

  logic                        s2_valid;
  c6502alu_pkg::exec_result_t  s2;
  c6502alu_pkg::exec_result_t  exec_res;

  logic                        advance;

  assign advance  = s1_valid && (!s2_valid || out.ready);
  assign in.ready = !s1_valid || advance;

  c6502alu_exec u_exec (
    .kind     (s1_kind),
    .operand  (s1_operand),
    .on_acc   (s1_on_acc),
    .selector (s1_sel),
    .acc      (acc),
    .x        (index_x),
    .y        (index_y),
    .flags    (flags),
    .res      (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
    if (in.valid && in.ready) begin
      s1_kind    <= c6502alu_pkg::kind_t'(in.kind);
      s1_operand <= in.operand;
      s1_on_acc  <= in.on_accumulator;
      s1_sel     <= in.selector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 8'h00;
      index_x <= 8'h00;
      index_y <= 8'h00;
      flags   <= c6502alu_pkg::FLAGS_RESET;
    end else if (advance) begin
      acc     <= exec_res.acc;
      index_x <= exec_res.x;
      index_y <= exec_res.y;
      flags   <= exec_res.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || out.ready) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2 <= exec_res;
    end
  end

  assign out.valid      = s2_valid;
  assign out.write_back = s2.wb;
  assign out.acc_out    = s2.acc;
  assign out.x_out      = s2.x;
  assign out.y_out      = s2.y;
  assign out.status_out = {s2.flags.n, s2.flags.v, 2'b11,
                           s2.flags.d, s2.flags.i, s2.flags.z, s2.flags.c};
  assign out.taken      = s2.taken;

  `C6502ALU_CHK_ALWAYS(a_reset_state, rst |=> (!s1_valid && !s2_valid && flags == c6502alu_pkg::FLAGS_RESET && acc == 8'h00), "reset did not clear pipeline and state")
  `C6502ALU_CHK_RUN(a_state_hold, !advance |=> ($stable(acc) && $stable(index_x) && $stable(index_y) && $stable(flags)), "architectural state changed without a transfer")
  `C6502ALU_CHK_RUN(a_result_matches_state, s2_valid |-> (s2.acc == acc && s2.x == index_x && s2.y == index_y && s2.flags == flags), "result register out of step with state")
  `C6502ALU_CHK_RUN(a_taken_only_tests, (advance && s1_kind != c6502alu_pkg::K_BRANCH && s1_kind != c6502alu_pkg::K_BBR && s1_kind != c6502alu_pkg::K_BBS) |=> !out.taken, "taken set by a non-test operation")

endmodule

`default_nettype wire
